// ===== hdl/bdcs_pkg.sv =====
`timescale 1ns / 1ps
package bdcs_pkg;
   localparam int CFG_IDX_BITS = 2;
   localparam logic [CFG_IDX_BITS-1:0] REG_DIM_STRIDE  = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_DIM_ORDER   = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_COUNT = 2'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_POINT = 2'd3;
   localparam int CFG_DATA_BITS = 17;
   localparam int T_BITS = 17;
   localparam logic [T_BITS-1:0] T_ONE = 17'd65536;

   // controller -> datapath commands
   typedef struct packed {
      logic load_wr;     // write input beat into lower store at wr_addr
      logic blend_rd;    // read lo/hi operands
      logic blend_wr;    // write blend result into lower store at wr_addr
      logic copy_rd;     // read lower store for copy to upper
      logic copy_wr;     // write copied value to upper store at wr_addr
      logic emit_rd;     // read a store for output
      logic emit_sel;    // 0 lower, 1 upper
   } bdcs_cmd_type;
endpackage

// ===== hdl/bdcs_chan_if.sv =====
`timescale 1ns / 1ps
interface bdcs_chan_if #(parameter int W = 32);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bdcs_datapath.sv =====
`timescale 1ns / 1ps
module bdcs_datapath
   import bdcs_pkg::*;
#(
   parameter int MAX_COEFFS = 32,
   parameter int COEFF_BITS = 32,
   parameter int AW = 5
) (
   input  logic                  clock,
   input  bdcs_cmd_type          cmd,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   input  logic [AW-1:0]         wr_addr,
   input  logic [T_BITS-1:0]     t_val,
   input  logic [31:0]           coeff_in,
   output logic [31:0]           rd_data
);
   localparam int EW = (COEFF_BITS < 32) ? COEFF_BITS : 32;

   logic signed [31:0] lower_mem [MAX_COEFFS];
   logic signed [31:0] upper_mem [MAX_COEFFS];
   logic signed [31:0] a_ff, b_ff, a_in, b_in;
   logic signed [50:0] pa_ff, pb_ff;
   logic signed [51:0] sum;
   logic signed [31:0] blend_val, ext_in;
   logic signed [17:0] t_s, tc_s;

   assign ext_in = 32'(signed'(coeff_in[EW-1:0]));
   assign t_s  = signed'({1'b0, t_val});
   assign tc_s = signed'({1'b0, T_ONE}) - t_s;
   assign sum  = 52'(pa_ff) + 52'(pb_ff);
   assign blend_val = sum[47:16];
   assign a_in = lower_mem[rd_addr_a];
   assign b_in = cmd.emit_sel ? upper_mem[rd_addr_b] : lower_mem[rd_addr_b];

   always_ff @(posedge clock) begin
      if (cmd.blend_rd || cmd.copy_rd || cmd.emit_rd) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      pa_ff <= 51'(a_ff) * 51'(tc_s);
      pb_ff <= 51'(b_ff) * 51'(t_s);
      if (cmd.load_wr) lower_mem[wr_addr] <= ext_in;
      if (cmd.blend_wr) lower_mem[wr_addr] <= blend_val;
      if (cmd.copy_wr) upper_mem[wr_addr] <= b_ff;
   end

   assign rd_data = b_ff;
endmodule

// ===== hdl/bdcs_ctrl.sv =====
`timescale 1ns / 1ps
module bdcs_ctrl
   import bdcs_pkg::*;
#(
   parameter int MAX_COEFFS = 32,
   parameter int AW = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_box,
   output logic [AW-1:0]     out_index,
   output logic              out_last,
   input  logic [5:0]        cfg_stride,
   input  logic [4:0]        cfg_order,
   input  logic [5:0]        cfg_count,
   output bdcs_cmd_type      cmd,
   output logic [AW-1:0]     rd_addr_a,
   output logic [AW-1:0]     rd_addr_b,
   output logic [AW-1:0]     wr_addr
);
   typedef enum logic [3:0] {
      S_LOAD, S_LANE, S_TOPCP, S_BRD, S_BM1, S_BM2, S_BWR, S_CPRD, S_CPWR,
      S_PASSRD, S_PASSWR, S_ERD, S_EWAIT, S_EOUT, S_NEXT
   } state_type;

   state_type  state_ff;
   logic [5:0] load_ff, count_ff, step_ff, i_ff, j_ff, ks_ff, k_ff, x_ff;
   logic [4:0] n_ff;
   logic [10:0] top_w, hi_w, base_w, bs_w, i_nx;
   logic [5:0] cnt_sat, stp_sat, load_nx, r_ff;
   logic       out_valid_ff;

   assign cnt_sat = (cfg_count == 6'd0) ? 6'd1 :
                    (cfg_count > 6'(MAX_COEFFS)) ? 6'(MAX_COEFFS) : cfg_count;
   assign stp_sat = (cfg_stride == 6'd0) ? 6'd1 : cfg_stride;
   assign load_nx = (load_ff < 6'd63) ? load_ff + 6'd1 : load_ff;
   assign base_w  = 11'(i_ff) + 11'(j_ff);
   assign top_w   = base_w + 11'(n_ff) * 11'(step_ff);
   assign hi_w    = base_w + 11'(k_ff) * 11'(step_ff);
   assign bs_w    = base_w + 11'(n_ff - 5'(ks_ff) - 5'd1) * 11'(step_ff);
   assign i_nx    = 11'(i_ff) + 11'(step_ff) * (11'(n_ff) + 11'd1);

   assign in_ready  = (state_ff == S_LOAD);
   assign out_valid = out_valid_ff;

   always_comb begin
      cmd = '0;
      rd_addr_a = AW'(hi_w - 11'(step_ff));
      rd_addr_b = AW'(hi_w);
      wr_addr   = AW'(hi_w);
      unique case (state_ff)
         S_LOAD: begin
            cmd.load_wr = in_valid && (load_ff < 6'(MAX_COEFFS));
            wr_addr = AW'(load_ff);
         end
         S_TOPCP, S_PASSRD: begin
            cmd.copy_rd = 1'b1;
            rd_addr_b = (state_ff == S_TOPCP) ? AW'(top_w) : AW'(hi_w);
         end
         S_BRD: cmd.blend_rd = 1'b1;
         S_BWR: cmd.blend_wr = 1'b1;
         S_CPRD: begin
            cmd.copy_rd = 1'b1;
            rd_addr_b = AW'(top_w);
         end
         S_CPWR: begin
            cmd.copy_wr = 1'b1;
            wr_addr = AW'(bs_w);
         end
         S_PASSWR: begin
            cmd.copy_wr = 1'b1;
            wr_addr = AW'(x_ff);
         end
         S_ERD: begin
            cmd.emit_rd = 1'b1;
            cmd.emit_sel = (r_ff >= count_ff);
            rd_addr_b = (r_ff >= count_ff) ? AW'(r_ff - count_ff) : AW'(r_ff);
         end
         default: ;
      endcase
      if (state_ff == S_TOPCP) begin
         cmd.copy_wr = 1'b0;
      end
   end

   // top copy: TOPCP reads, PASSWR writes it back through x_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         load_ff <= '0;
         out_valid_ff <= 1'b0;
         count_ff <= 6'd2;
         step_ff <= 6'd1;
         n_ff <= 5'd1;
         i_ff <= '0; j_ff <= '0; ks_ff <= '0; k_ff <= '0; x_ff <= '0; r_ff <= '0;
         out_box <= 1'b0; out_index <= '0; out_last <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: if (in_valid) begin
               if (load_nx >= cnt_sat) begin
                  load_ff <= '0;
                  count_ff <= cnt_sat;
                  step_ff <= stp_sat;
                  n_ff <= cfg_order;
                  i_ff <= '0; j_ff <= '0;
                  state_ff <= S_LANE;
               end else begin
                  load_ff <= load_nx;
               end
            end
            S_LANE: begin
               if (i_ff >= count_ff) begin
                  r_ff <= '0;
                  state_ff <= S_ERD;
               end else if (base_w >= 11'(count_ff)) begin
                  // lane starts past the count: nothing to move
                  state_ff <= S_NEXT;
               end else if (top_w >= 11'(count_ff)) begin
                  k_ff <= '0;
                  state_ff <= S_PASSRD;
               end else begin
                  k_ff <= 6'(n_ff);
                  x_ff <= 6'(top_w);
                  state_ff <= S_TOPCP;
               end
            end
            S_TOPCP: state_ff <= S_PASSWR;   // top copy, then blending
            S_PASSRD: begin
               x_ff <= 6'(hi_w);
               state_ff <= S_PASSWR;
            end
            S_PASSWR: begin
               if (top_w < 11'(count_ff)) begin
                  // came from top copy: start blend passes
                  ks_ff <= '0;
                  k_ff <= 6'(n_ff);
                  state_ff <= (n_ff == 5'd0) ? S_NEXT : S_BRD;
               end else if (k_ff >= 6'(n_ff) ||
                            base_w + 11'(k_ff + 6'd1) * 11'(step_ff) >= 11'(count_ff)) begin
                  state_ff <= S_NEXT;
               end else begin
                  k_ff <= k_ff + 6'd1;
                  state_ff <= S_PASSRD;
               end
            end
            S_BRD: state_ff <= S_BM1;
            S_BM1: state_ff <= S_BM2;
            S_BM2: state_ff <= S_BWR;
            S_BWR: begin
               if (k_ff > ks_ff + 6'd1) begin
                  k_ff <= k_ff - 6'd1;
                  state_ff <= S_BRD;
               end else begin
                  state_ff <= S_CPRD;
               end
            end
            S_CPRD: state_ff <= S_CPWR;
            S_CPWR: begin
               if (top_w >= 11'(count_ff) || n_ff == 5'd0 ||
                   ks_ff + 6'd1 >= 6'(n_ff)) begin
                  state_ff <= S_NEXT;
               end else begin
                  ks_ff <= ks_ff + 6'd1;
                  k_ff <= 6'(n_ff);
                  state_ff <= S_BRD;
               end
            end
            S_NEXT: begin
               // next lane; block start clamps at the count
               if (j_ff + 6'd1 >= step_ff) begin
                  j_ff <= '0;
                  i_ff <= (i_nx >= 11'(count_ff)) ? count_ff : 6'(i_nx);
               end else begin
                  j_ff <= j_ff + 6'd1;
               end
               state_ff <= S_LANE;
            end
            S_ERD: state_ff <= S_EWAIT;
            S_EWAIT: begin
               out_valid_ff <= 1'b1;
               out_box <= (r_ff >= count_ff);
               out_index <= (r_ff >= count_ff) ? AW'(r_ff - count_ff) : AW'(r_ff);
               out_last <= (r_ff + 6'd1 == {count_ff[4:0], 1'b0});
               state_ff <= S_EOUT;
            end
            S_EOUT: if (out_ready) begin
               out_valid_ff <= 1'b0;
               if (r_ff + 6'd1 == {count_ff[4:0], 1'b0}) begin
                  state_ff <= S_LOAD;
               end else begin
                  r_ff <= r_ff + 6'd1;
                  state_ff <= S_ERD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

// ===== hdl/bernstein_de_casteljau_split_top.sv =====
`timescale 1ns / 1ps
// Loads coeff_count signed Q16.16 coefficients, one per req beat, then splits
// the tensor along one dimension at point t and sends 2*count rsp beats:
// the lower sub-box in index order, then the upper one, job_last on the final
// beat. Loading takes one cycle per beat. The split runs on one blend unit
// (read, two multiply stages, write); a lane that runs past the count is
// copied to the upper store without blending. Each result is read, then held
// on rsp until taken. No req beat is taken during the split and emit phases.
module bernstein_de_casteljau_split_top
   import bdcs_pkg::*;
#(
   parameter int MAX_COEFFS = 32,
   parameter int COEFF_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   bdcs_chan_if.sink   req,
   bdcs_chan_if.source rsp,
   bdcs_chan_if.sink   csr
);
   localparam int AW = $clog2(MAX_COEFFS);

   logic [5:0]  stride_ff, count_ff;
   logic [4:0]  order_ff;
   logic [16:0] split_ff;
   logic [T_BITS-1:0] t_val;
   logic [CFG_IDX_BITS-1:0] csr_idx;
   logic [CFG_DATA_BITS-1:0] csr_val;
   bdcs_cmd_type cmd;
   logic [AW-1:0] ra, rb, wa, oi;
   logic ob, ol;
   logic [31:0] rdat;

   assign csr.ready = 1'b1;
   assign csr_idx = csr.data[CFG_DATA_BITS +: CFG_IDX_BITS];
   assign csr_val = csr.data[CFG_DATA_BITS-1:0];
   assign t_val = (split_ff > T_ONE) ? T_ONE : split_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 6'd1;
         order_ff <= 5'd1;
         count_ff <= 6'd2;
         split_ff <= 17'd32768;
      end else if (csr.valid) begin
         unique case (csr_idx)
            REG_DIM_STRIDE:  stride_ff <= csr_val[5:0];
            REG_DIM_ORDER:   order_ff <= csr_val[4:0];
            REG_COEFF_COUNT: count_ff <= csr_val[5:0];
            REG_SPLIT_POINT: split_ff <= csr_val;
            default: ;
         endcase
      end
   end

   bdcs_ctrl #(.MAX_COEFFS(MAX_COEFFS), .AW(AW)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_box(ob), .out_index(oi), .out_last(ol),
      .cfg_stride(stride_ff), .cfg_order(order_ff), .cfg_count(count_ff),
      .cmd, .rd_addr_a(ra), .rd_addr_b(rb), .wr_addr(wa)
   );

   bdcs_datapath #(.MAX_COEFFS(MAX_COEFFS), .COEFF_BITS(COEFF_BITS), .AW(AW)) u_dp (
      .clock, .cmd, .rd_addr_a(ra), .rd_addr_b(rb), .wr_addr(wa),
      .t_val, .coeff_in(req.data[31:0]), .rd_data(rdat)
   );

   // rsp data: {sub_box, coeff_index, coeff_out, job_last}
   assign rsp.data = {ob, 5'(oi), rdat, ol};

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("load during emit");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp dropped");
`endif
endmodule
